// ===== sv/encoder_speed_p_feedforward_drive_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the encoder speed drive
// Shared concurrent assertion forms, clocked on clk.
// ----------------------------------------------------------------------------
`ifndef ENCODER_SPEED_P_FEEDFORWARD_DRIVE_MACROS_SVH
`define ENCODER_SPEED_P_FEEDFORWARD_DRIVE_MACROS_SVH

// Assertion that is switched off while reset is held.
`define ESPF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion that also holds through reset.
`define ESPF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/espf_pkg.sv =====
// ----------------------------------------------------------------------------
// espf_pkg
// Widths, types and register codes shared by the encoder speed drive.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package espf_pkg;

  // Serial multiplier: multiplicand width, multiplier width, product width.
  localparam int MUL_MCAND_W  = 32;
  localparam int MUL_MPLIER_W = 17;
  localparam int MUL_PROD_W   = MUL_MCAND_W + MUL_MPLIER_W;
  localparam int MUL_CNT_W    = $clog2(MUL_MPLIER_W);

  // Serial divider: numerator is |delta| * 60e6, denominator dt * pulses.
  localparam int DIV_NUM_W  = 42;
  localparam int DIV_DEN_W  = 48;
  localparam int DIV_QUOT_W = 16;
  localparam int DIV_CNT_W  = $clog2(DIV_NUM_W);

  // Counts per revolution to rpm: 60 s times 1e6 us.
  localparam logic [MUL_MCAND_W-1:0] RPM_SCALE = 32'd60000000;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_PROP_GAIN = 2'd0,
    CFG_FF_GAIN   = 2'd1,
    CFG_PPR       = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic                  done;
    logic [MUL_PROD_W-1:0] prod;
  } mul_res_t;

  typedef struct packed {
    logic                  done;
    logic                  ovf;
    logic [DIV_QUOT_W-1:0] quot;
  } div_res_t;

endpackage

// ===== sv/espf_sermul.sv =====
// ----------------------------------------------------------------------------
// espf_sermul
// Unsigned shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module espf_sermul import espf_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [MUL_MCAND_W-1:0]  mcand,
  input  logic [MUL_MPLIER_W-1:0] mplier,
  output mul_res_t                res
);

  localparam logic [MUL_CNT_W-1:0] LAST_STEP = MUL_CNT_W'(MUL_MPLIER_W - 1);

  logic                   busy_r;
  logic                   done_r;
  logic [MUL_CNT_W-1:0]   cnt_r;
  logic [MUL_MCAND_W-1:0] mcand_r;
  logic [MUL_PROD_W-1:0]  p_r;
  logic [MUL_MCAND_W:0]   sum;
  logic [MUL_PROD_W-1:0]  p_nxt;

  // Add the multiplicand into the upper half when the bit leaving is set,
  // then shift the whole product right by one.
  always_comb begin
    sum   = {1'b0, p_r[MUL_PROD_W-1:MUL_MPLIER_W]}
          + (p_r[0] ? {1'b0, mcand_r} : {(MUL_MCAND_W + 1){1'b0}});
    p_nxt = {sum, p_r[MUL_MPLIER_W-1:1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand_r <= mcand;
      p_r     <= {{MUL_MCAND_W{1'b0}}, mplier};
    end else if (busy_r) begin
      p_r <= p_nxt;
    end
  end

  assign res.done = done_r;
  assign res.prod = p_r;

endmodule

// ===== sv/espf_serdiv.sv =====
// ----------------------------------------------------------------------------
// espf_serdiv
// Restoring divider, one quotient bit per cycle, with a sticky overflow
// flag for quotients that do not fit in sixteen bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module espf_serdiv import espf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [DIV_NUM_W-1:0] num,
  input  logic [DIV_DEN_W-1:0] den,
  output div_res_t             res
);

  localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(DIV_NUM_W - 1);

  logic                  busy_r;
  logic                  done_r;
  logic [DIV_CNT_W-1:0]  cnt_r;
  logic [DIV_NUM_W-1:0]  num_r;
  logic [DIV_DEN_W-1:0]  den_r;
  logic [DIV_DEN_W-1:0]  rem_r;
  logic [DIV_QUOT_W-1:0] quot_r;
  logic                  ovf_r;
  logic [DIV_DEN_W:0]    trial;
  logic                  qbit;
  logic [DIV_DEN_W-1:0]  rem_nxt;

  always_comb begin
    trial   = {rem_r, num_r[DIV_NUM_W-1]};
    qbit    = (trial >= {1'b0, den_r});
    rem_nxt = qbit ? DIV_DEN_W'(trial - {1'b0, den_r}) : trial[DIV_DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // A set bit pushed out of the top of the quotient marks an overflow.
  always_ff @(posedge clk) begin
    if (start) begin
      num_r  <= num;
      den_r  <= den;
      rem_r  <= '0;
      quot_r <= '0;
      ovf_r  <= 1'b0;
    end else if (busy_r) begin
      num_r  <= {num_r[DIV_NUM_W-2:0], 1'b0};
      rem_r  <= rem_nxt;
      quot_r <= {quot_r[DIV_QUOT_W-2:0], qbit};
      ovf_r  <= ovf_r | quot_r[DIV_QUOT_W-1];
    end
  end

  assign res.done = done_r;
  assign res.ovf  = ovf_r;
  assign res.quot = quot_r;

endmodule

// ===== sv/encoder_speed_p_feedforward_drive.sv =====
// ----------------------------------------------------------------------------
// encoder_speed_p_feedforward_drive
// Encoder speed measurement with a proportional plus feedforward drive stage.
// ----------------------------------------------------------------------------
// Each input beat carries a target speed, a microsecond timestamp and an
// encoder count; each produces exactly one output beat with the speed used,
// the two direction lines, the duty and a clip flag. The block works on one
// beat at a time. When at least MIN_INTERVAL_US microseconds have gone by
// since the last measurement, a fresh speed is measured: two 17-step serial
// multipliers form |delta| * 60e6 and dt times the counts per revolution, and
// a 42-step serial divider takes their quotient. Otherwise the held speed is
// reused and only one pass of the multipliers, for the gain products, is made.
// If the previous result is still waiting in the output register when a new
// one is ready, the block holds in its last step until the output moves. The
// input is stalled while a beat is in flight; the output sits in its own
// register, so a new beat may be taken while a result waits. Configuration
// writes are always ready and must be made while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module encoder_speed_p_feedforward_drive import espf_pkg::*; #(
  parameter int unsigned MIN_INTERVAL_US = 1000
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_target_rpm,
  input  logic [31:0] in_time_us,
  input  logic [15:0] in_enc_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_measured_rpm,
  output logic        out_drive_a,
  output logic        out_drive_b,
  output logic [7:0]  out_duty,
  output logic        out_saturated,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // The step sequencer: CHECK decides between a fresh measurement and the
  // held speed, MUL1 and DIV measure, ERR starts the gain products, MUL2
  // waits for them and FIN hands the result to the output register.
  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_CHECK = 7'b0000010,
    ST_MUL1  = 7'b0000100,
    ST_DIV   = 7'b0001000,
    ST_ERR   = 7'b0010000,
    ST_MUL2  = 7'b0100000,
    ST_FIN   = 7'b1000000
  } state_t;

  localparam logic [31:0] MIN_DT = 32'(MIN_INTERVAL_US);

  state_t state_r, state_nxt;

  // Configuration registers.
  logic signed [15:0] prop_gain_r;
  logic signed [15:0] ff_gain_r;
  logic        [15:0] ppr_r;

  // Persistent measurement state.
  logic        [31:0] prev_time_r;
  logic        [15:0] prev_count_r;
  logic signed [15:0] held_rpm_r;
  logic        [7:0]  held_duty_r;

  // Beat being worked on.
  logic signed [15:0] target_r;
  logic        [31:0] time_r;
  logic        [15:0] count_r;
  logic        [31:0] dt_r;
  logic               dneg_r;
  logic signed [15:0] rpm_r;
  logic               pneg_r;
  logic               fneg_r;
  logic signed [34:0] sum_r;

  // Output register.
  logic               out_valid_r;
  logic        [15:0] out_rpm_r;
  logic               out_a_r;
  logic               out_b_r;
  logic        [7:0]  out_duty_r;
  logic               out_sat_r;

  // Serial units.
  logic                    mul_start;
  logic [MUL_MCAND_W-1:0]  mula_mcand;
  logic [MUL_MPLIER_W-1:0] mula_mplier;
  logic [MUL_MCAND_W-1:0]  mulb_mcand;
  logic [MUL_MPLIER_W-1:0] mulb_mplier;
  mul_res_t                mula_res;
  mul_res_t                mulb_res;
  logic                    div_start;
  div_res_t                div_res;

  // Combinational helpers.
  logic               in_acc;
  logic               out_free;
  logic               measure;
  logic        [15:0] delta;
  logic               dneg;
  logic        [15:0] dmag;
  logic        [15:0] ppr_eff;
  logic signed [16:0] err;
  logic        [16:0] err_mag;
  logic        [15:0] pg_mag;
  logic        [15:0] ff_mag;
  logic        [15:0] tgt_mag;
  logic signed [15:0] rpm_calc;
  logic signed [34:0] term_p;
  logic signed [34:0] term_f;
  logic        [34:0] sum_mag;
  logic        [26:0] cmd_mag;
  logic               cmd_nz;

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;

  // Encoder delta wraps to signed 16 bits; its magnitude always fits in
  // sixteen unsigned bits, including the most negative value.
  always_comb begin
    measure = (dt_r >= MIN_DT);
    delta   = count_r - prev_count_r;
    dneg    = delta[15];
    dmag    = dneg ? (16'd0 - delta) : delta;
    ppr_eff = (ppr_r == 16'd0) ? 16'd1 : ppr_r;
  end

  // Speed error and operand magnitudes for the gain products.
  always_comb begin
    err     = 17'(target_r) - 17'(rpm_r);
    err_mag = err[16] ? 17'(-err) : 17'(err);
    pg_mag  = prop_gain_r[15] ? 16'(-prop_gain_r) : 16'(prop_gain_r);
    ff_mag  = ff_gain_r[15] ? 16'(-ff_gain_r) : 16'(ff_gain_r);
    tgt_mag = target_r[15] ? 16'(-target_r) : 16'(target_r);
  end

  // Both multipliers start together, either for the measurement operands or
  // for the gain products.
  always_comb begin
    mul_start = ((state_r == ST_CHECK) && measure) || (state_r == ST_ERR);
    if (state_r == ST_ERR) begin
      mula_mcand  = {16'd0, pg_mag};
      mula_mplier = err_mag;
      mulb_mcand  = {16'd0, ff_mag};
      mulb_mplier = {1'b0, tgt_mag};
    end else begin
      mula_mcand  = RPM_SCALE;
      mula_mplier = {1'b0, dmag};
      mulb_mcand  = dt_r;
      mulb_mplier = {1'b0, ppr_eff};
    end
  end

  assign div_start = (state_r == ST_MUL1) && mula_res.done;

  // Quotient to signed rpm, saturated to the 16-bit range.
  always_comb begin
    if (dneg_r) begin
      if (div_res.ovf || (div_res.quot > 16'd32768)) begin
        rpm_calc = 16'sh8000;
      end else begin
        rpm_calc = 16'(16'd0 - div_res.quot);
      end
    end else begin
      if (div_res.ovf || (div_res.quot > 16'd32767)) begin
        rpm_calc = 16'sh7FFF;
      end else begin
        rpm_calc = div_res.quot;
      end
    end
  end

  // Signed gain products and the command; the divide by 256 truncates the
  // magnitude, which is the same as truncation toward zero.
  always_comb begin
    term_p  = pneg_r ? -35'(mula_res.prod[32:0]) : 35'(mula_res.prod[32:0]);
    term_f  = fneg_r ? -35'(mulb_res.prod[32:0]) : 35'(mulb_res.prod[32:0]);
    sum_mag = sum_r[34] ? 35'(-sum_r) : 35'(sum_r);
    cmd_mag = sum_mag[34:8];
    cmd_nz  = (cmd_mag != 27'd0);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_acc) state_nxt = ST_CHECK;
      ST_CHECK: state_nxt = measure ? ST_MUL1 : ST_ERR;
      ST_MUL1:  if (mula_res.done) state_nxt = ST_DIV;
      ST_DIV:   if (div_res.done) state_nxt = ST_ERR;
      ST_ERR:   state_nxt = ST_MUL2;
      ST_MUL2:  if (mula_res.done) state_nxt = ST_FIN;
      ST_FIN:   if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Control state, configuration, the persistent measurement state and the output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      prop_gain_r  <= 16'sd256;
      ff_gain_r    <= 16'sd0;
      ppr_r        <= 16'd1;
      prev_time_r  <= '0;
      prev_count_r <= '0;
      held_rpm_r   <= '0;
      held_duty_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_PROP_GAIN: prop_gain_r <= cfg_data;
          CFG_FF_GAIN:   ff_gain_r   <= cfg_data;
          CFG_PPR:       ppr_r       <= cfg_data;
          default:       ;
        endcase
      end
      if ((state_r == ST_DIV) && div_res.done) begin
        prev_time_r  <= time_r;
        prev_count_r <= count_r;
        held_rpm_r   <= rpm_calc;
      end
      if ((state_r == ST_FIN) && out_free) begin
        out_valid_r <= 1'b1;
        if (cmd_nz) begin
          held_duty_r <= (cmd_mag > 27'd255) ? 8'hFF : cmd_mag[7:0];
        end
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working registers of the beat and the output payload.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      target_r <= in_target_rpm;
      time_r   <= in_time_us;
      count_r  <= in_enc_count;
      dt_r     <= in_time_us - prev_time_r;
    end
    if (state_r == ST_CHECK) begin
      dneg_r <= dneg;
      if (!measure) begin
        rpm_r <= held_rpm_r;
      end
    end
    if ((state_r == ST_DIV) && div_res.done) begin
      rpm_r <= rpm_calc;
    end
    if (state_r == ST_ERR) begin
      pneg_r <= prop_gain_r[15] ^ err[16];
      fneg_r <= ff_gain_r[15] ^ target_r[15];
    end
    if ((state_r == ST_MUL2) && mula_res.done) begin
      sum_r <= term_p + term_f;
    end
    if ((state_r == ST_FIN) && out_free) begin
      out_rpm_r <= rpm_r;
      out_a_r   <= cmd_nz && !sum_r[34];
      out_b_r   <= cmd_nz && sum_r[34];
      if (!cmd_nz) begin
        out_duty_r <= held_duty_r;
        out_sat_r  <= 1'b0;
      end else if (cmd_mag > 27'd255) begin
        out_duty_r <= 8'hFF;
        out_sat_r  <= 1'b1;
      end else begin
        out_duty_r <= cmd_mag[7:0];
        out_sat_r  <= 1'b0;
      end
    end
  end

  espf_sermul u_mul_a (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .mcand  (mula_mcand),
    .mplier (mula_mplier),
    .res    (mula_res)
  );

  espf_sermul u_mul_b (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .mcand  (mulb_mcand),
    .mplier (mulb_mplier),
    .res    (mulb_res)
  );

  espf_serdiv u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (mula_res.prod[DIV_NUM_W-1:0]),
    .den   (mulb_res.prod[DIV_DEN_W-1:0]),
    .res   (div_res)
  );

  assign out_valid        = out_valid_r;
  assign out_measured_rpm = out_rpm_r;
  assign out_drive_a      = out_a_r;
  assign out_drive_b      = out_b_r;
  assign out_duty         = out_duty_r;
  assign out_saturated    = out_sat_r;

endmodule

// ===== sv/espf_checker.sv =====
// ----------------------------------------------------------------------------
// espf_checker
// Port-level checks on the encoder speed drive, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "encoder_speed_p_feedforward_drive_macros.svh"

module espf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_measured_rpm,
  input logic        out_drive_a,
  input logic        out_drive_b,
  input logic [7:0]  out_duty,
  input logic        out_saturated
);

  // A held result beat keeps its valid, its measured speed and its duty.
  `ESPF_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_measured_rpm) && $stable(out_duty), "stalled output beat changed")

  // The two direction lines never drive together.
  `ESPF_ASSERT(a_dir_excl, out_valid |-> !(out_drive_a && out_drive_b), "both direction lines high")

  // A clipped command is never a brake and always shows full duty.
  `ESPF_ASSERT(a_sat_duty, out_valid && out_saturated |-> (out_duty == 8'hFF) && (out_drive_a || out_drive_b), "clip flag without full duty")

  // The block takes one beat at a time: after an accepted beat the input stalls.
  `ESPF_ASSERT(a_one_beat, in_valid && !in_stall |=> in_stall, "second beat taken while busy")

endmodule

bind encoder_speed_p_feedforward_drive espf_checker u_espf_checker (.*);

// ===== verif/encoder_speed_p_feedforward_drive_tb.sv =====
// ----------------------------------------------------------------------------
// encoder_speed_p_feedforward_drive_tb
// Self-checking bench for the encoder speed drive. A queue of control steps
// feeds a burst-driven sender, a stalling receiver takes the results, and a
// beat-level predictor of the speed measurement and drive stage checks
// every result beat field by field across several gain settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module encoder_speed_p_feedforward_drive_tb import espf_pkg::*; ();

  localparam int unsigned MIN_INTERVAL_US = 1000;
  // Cycles with no handshake on any channel before the run is abandoned.
  // The slowest legitimate stretch is the long receiver hold-off plus one
  // measuring beat, well under this figure.
  localparam int unsigned IDLE_LIMIT      = 20000;
  // Quiet cycles after the last result.
  localparam int unsigned SETTLE_CYCLES   = 120;
  localparam int unsigned LONG_HOLD       = 400;

  typedef struct packed {
    logic [15:0] target_rpm;
    logic [31:0] time_us;
    logic [15:0] enc_count;
  } step_t;

  typedef struct packed {
    logic [15:0] measured_rpm;
    logic        drive_a;
    logic        drive_b;
    logic [7:0]  duty;
    logic        saturated;
  } drive_t;

  // Block ports. Every input holds a known value from time zero.
  logic        clk           = 1'b0;
  logic        rst_n         = 1'b0;
  logic        in_valid      = 1'b0;
  logic        in_stall;
  logic [15:0] in_target_rpm = '0;
  logic [31:0] in_time_us    = '0;
  logic [15:0] in_enc_count  = '0;
  logic        out_valid;
  logic        out_stall     = 1'b0;
  logic [15:0] out_measured_rpm;
  logic        out_drive_a;
  logic        out_drive_b;
  logic [7:0]  out_duty;
  logic        out_saturated;
  logic        cfg_valid     = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index     = '0;
  logic [15:0] cfg_data      = '0;

  encoder_speed_p_feedforward_drive #(
    .MIN_INTERVAL_US(MIN_INTERVAL_US)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_target_rpm    (in_target_rpm),
    .in_time_us       (in_time_us),
    .in_enc_count     (in_enc_count),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_measured_rpm (out_measured_rpm),
    .out_drive_a      (out_drive_a),
    .out_drive_b      (out_drive_b),
    .out_duty         (out_duty),
    .out_saturated    (out_saturated),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // Control steps waiting to be offered, and drive results still owed.
  step_t  step_q[$];
  drive_t drive_owed_q[$];

  // Our own copy of the registers, at their reset values.
  logic [15:0] prop_gain = 16'd256;
  logic [15:0] ff_gain   = 16'd0;
  logic [15:0] ppr       = 16'd1;

  // Our own copy of the measurement state, cleared as the block is by reset.
  logic [31:0] spd_prev_time  = '0;
  logic [15:0] spd_prev_count = '0;
  int          spd_held_rpm   = 0;
  logic [7:0]  spd_held_duty  = '0;

  // Running position of the generated encoder and clock streams.
  logic [31:0] gen_time  = '0;
  logic [15:0] gen_count = '0;

  int unsigned in_offered   = 0;
  int unsigned in_taken     = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches   = 0;
  int unsigned held_steps   = 0;
  int unsigned clipped      = 0;
  int unsigned braked       = 0;
  int unsigned cfg_writes   = 0;
  int unsigned idle_cycles  = 0;

  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;
  int unsigned hold_left  = 0;
  bit          hold_done  = 1'b0;
  int unsigned seg_left   = 0;
  int unsigned seg_kind   = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor: one control step in, one drive result out. It measures a new
  // speed when the interval is long enough, otherwise reuses the held one,
  // then forms the proportional plus feedforward command from Q8.8 gains.
  // --------------------------------------------------------------------------
  function automatic drive_t predict_drive(step_t s);
    logic [31:0]     dt;
    logic [15:0]     raw_delta;
    int              delta;
    int              rpm;
    int              tgt;
    longint unsigned den;
    longint unsigned num;
    longint unsigned quot;
    longint          sum;
    longint          mag;
    drive_t          r;
    dt = s.time_us - spd_prev_time;
    if (dt < MIN_INTERVAL_US) begin
      rpm = spd_held_rpm;
      held_steps++;
    end else begin
      // The count difference wraps into signed 16 bits, so a jump of exactly
      // half the range reads as a reverse move.
      raw_delta = s.enc_count - spd_prev_count;
      delta     = int'($signed(raw_delta));
      // A zero count per revolution is taken as one.
      den  = 64'(dt) * 64'((ppr == 16'd0) ? 16'd1 : ppr);
      num  = 64'((delta < 0) ? -delta : delta) * 64'd60000000;
      quot = num / den;
      if (delta < 0) begin
        rpm = (quot > 64'd32768) ? -32768 : -int'(quot);
      end else begin
        rpm = (quot > 64'd32767) ? 32767 : int'(quot);
      end
      spd_prev_time  = s.time_us;
      spd_prev_count = s.enc_count;
      spd_held_rpm   = rpm;
    end

    tgt = int'($signed(s.target_rpm));
    sum = longint'(int'($signed(prop_gain))) * longint'(tgt - rpm)
        + longint'(int'($signed(ff_gain))) * longint'(tgt);
    // Truncation toward zero: shift the magnitude, not the signed sum.
    mag = ((sum < 0) ? -sum : sum) >> 8;

    r = '0;
    r.measured_rpm = 16'(rpm);
    if (mag != 0) begin
      r.drive_a = (sum > 0);
      r.drive_b = (sum < 0);
      if (mag > 255) begin
        spd_held_duty = 8'd255;
        r.saturated   = 1'b1;
        clipped++;
      end else begin
        spd_held_duty = 8'(mag);
      end
    end else begin
      // Braking: both lines low and the previous duty repeated.
      braked++;
    end
    r.duty = spd_held_duty;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    mismatches++;
    $display("[%0t] MISMATCH result %0d %s: got %0d, expected %0d",
             $time, results_seen, what, got, want);
  endtask

  task automatic push_step(logic [15:0] tgt, logic [31:0] tm, logic [15:0] cnt);
    step_t s;
    s.target_rpm = tgt;
    s.time_us    = tm;
    s.enc_count  = cnt;
    gen_time     = tm;
    gen_count    = cnt;
    step_q.push_back(s);
  endtask

  // Random steps. Most follow a plausible motor: time moves forward by a
  // measurement interval or more and the count drifts a little. Some steps
  // come too soon and reuse the held speed, and a few jump anywhere at all.
  task automatic queue_random_steps(int n);
    step_t s;
    int    r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        gen_time = gen_time + $urandom_range(0, MIN_INTERVAL_US - 1);
      end else if (r < 85) begin
        gen_time = gen_time + $urandom_range(MIN_INTERVAL_US, 20000);
      end else if (r < 95) begin
        gen_time = $urandom;
      end else begin
        gen_time = gen_time + MIN_INTERVAL_US;
      end

      r = $urandom_range(0, 99);
      if (r < 80) begin
        gen_count = gen_count + 16'($urandom_range(0, 400)) - 16'd200;
      end else if (r < 90) begin
        gen_count = gen_count + 16'($urandom);
      end else begin
        gen_count = 16'($urandom);
      end

      r = $urandom_range(0, 99);
      if (r < 60) begin
        s.target_rpm = 16'($urandom_range(0, 1000)) - 16'd500;
      end else if (r < 90) begin
        s.target_rpm = 16'($urandom_range(0, 10000)) - 16'd5000;
      end else begin
        s.target_rpm = 16'($urandom);
      end
      s.time_us   = gen_time;
      s.enc_count = gen_count;
      step_q.push_back(s);
    end
  endtask

  // Register writes are only made with the block idle, so the predictor's
  // copy can be updated at the handshake itself.
  task automatic write_drive_reg(cfg_idx_t idx, logic [15:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_PROP_GAIN: prop_gain = value;
      CFG_FF_GAIN:   ff_gain   = value;
      CFG_PPR:       ppr       = value;
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Waits until every queued step has been taken and answered, then lets the
  // block settle before anything else touches it.
  task automatic wait_drained();
    while (step_q.size() != 0 || in_offered != in_taken || drive_owed_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Sender. Works in bursts of random length separated by random gaps; a gap
  // of zero gives back-to-back stretches. A beat that has been offered stays
  // put until the monitor has seen it accepted.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin : sender
    step_t s;
    if (rst_n && in_offered == in_taken) begin
      if (gap_left != 0) begin
        gap_left = gap_left - 1;
        in_valid <= 1'b0;
      end else if (step_q.size() != 0) begin
        s = step_q.pop_front();
        in_valid      <= 1'b1;
        in_target_rpm <= s.target_rpm;
        in_time_us    <= s.time_us;
        in_enc_count  <= s.enc_count;
        in_offered++;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 12);
          gap_left   = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 25);
        end else begin
          burst_left = burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver. Stalls on segments of varying density, including segments with
  // no stall at all. Once, partway through, it holds off for a long stretch
  // while steps are still being offered, so the result register fills and
  // the block has to stall its input.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin : receiver
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else if (!hold_done && results_seen >= 150 && step_q.size() != 0) begin
      hold_done = 1'b1;
      hold_left = LONG_HOLD;
      out_stall <= 1'b1;
    end else begin
      if (seg_left == 0) begin
        seg_kind = $urandom_range(0, 3);
        seg_left = $urandom_range(5, 60);
      end
      seg_left = seg_left - 1;
      case (seg_kind)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 1) == 0);
        2:       out_stall <= ($urandom_range(0, 9) < 8);
        default: out_stall <= ($urandom_range(0, 9) < 2);
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Monitor and watchdog. Accepted input beats go through the predictor;
  // accepted result beats are checked against the oldest prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    step_t  s;
    drive_t want;
    bit     moved;
    moved = 1'b0;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        s.target_rpm = in_target_rpm;
        s.time_us    = in_time_us;
        s.enc_count  = in_enc_count;
        drive_owed_q.push_back(predict_drive(s));
        in_taken++;
        moved = 1'b1;
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        moved = 1'b1;
        if (drive_owed_q.size() == 0) begin
          report_mismatch("with no step outstanding, measured_rpm",
                          longint'($signed(out_measured_rpm)), 0);
        end else begin
          want = drive_owed_q.pop_front();
          if (out_measured_rpm !== want.measured_rpm)
            report_mismatch("measured_rpm", longint'($signed(out_measured_rpm)),
                            longint'($signed(want.measured_rpm)));
          if (out_drive_a !== want.drive_a)
            report_mismatch("drive_a", out_drive_a, want.drive_a);
          if (out_drive_b !== want.drive_b)
            report_mismatch("drive_b", out_drive_b, want.drive_b);
          if (out_duty !== want.duty)
            report_mismatch("duty", out_duty, want.duty);
          if (out_saturated !== want.saturated)
            report_mismatch("saturated", out_saturated, want.saturated);
        end
      end
      if (cfg_valid && cfg_ready)
        moved = 1'b1;
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[%0t] Watchdog: no beat moved for %0d cycles, %0d results owed",
                 $time, IDLE_LIMIT, drive_owed_q.size());
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequence: reset, directed and random steps under the reset gains, then
  // random steps under a series of register settings that include both ends of
  // each register's range. Each phase drains fully before the registers change.
  // --------------------------------------------------------------------------
  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset gains: the command is simply target minus measured speed.
    push_step(16'd0,      32'd0,          16'd0);      // no time passed, brake
    push_step(16'd100,    32'd999,        16'd5);      // one short of the interval
    push_step(16'd0,      32'd1000,       16'd0);      // exactly the interval
    push_step(16'd32767,  32'd2000,       16'd1);      // speed clips high
    push_step(16'h8000,   32'd3000,       16'd1);      // most negative target
    push_step(16'd32767,  32'd4000,       16'd32769);  // half-range jump reads reverse
    push_step(16'hFED4,   32'd5000,       16'd32768);  // speed clips low
    push_step(16'h8000,   32'hFFFF_FF00,  16'hFFFF);   // very long interval
    push_step(16'd0,      32'h0000_0300,  16'h0002);   // clock and count both wrap
    push_step(16'd200,    32'h0000_0500,  16'h0000);   // short after wrap, held
    push_step(16'd32767,  32'hFFFF_FFFF,  16'h8000);   // all-ones timestamp
    push_step(16'hFFFF,   32'h8000_0000,  16'h7FFF);
    push_step(16'd1,      32'h8000_03E8,  16'h7FFF);   // zero delta, tiny command
    push_step(16'd0,      32'h8000_07D0,  16'h7FFF);   // brake keeps the last duty
    queue_random_steps(40);
    wait_drained();

    write_drive_reg(CFG_PROP_GAIN, 16'd256);
    write_drive_reg(CFG_FF_GAIN,   16'd128);
    write_drive_reg(CFG_PPR,       16'd1024);
    queue_random_steps(130);
    wait_drained();

    // Extremes of every register.
    write_drive_reg(CFG_PROP_GAIN, 16'h8000);
    write_drive_reg(CFG_FF_GAIN,   16'h7FFF);
    write_drive_reg(CFG_PPR,       16'hFFFF);
    queue_random_steps(90);
    wait_drained();

    // A zero count per revolution must behave as one.
    write_drive_reg(CFG_PROP_GAIN, 16'h7FFF);
    write_drive_reg(CFG_FF_GAIN,   16'h8000);
    write_drive_reg(CFG_PPR,       16'd0);
    queue_random_steps(90);
    wait_drained();

    // Small gains so the duty sweeps through its unclipped range.
    write_drive_reg(CFG_PROP_GAIN, 16'd64);
    write_drive_reg(CFG_FF_GAIN,   16'd32);
    write_drive_reg(CFG_PPR,       16'd100);
    queue_random_steps(130);
    wait_drained();

    // Zero gains: every step brakes and the duty must stay where it was.
    write_drive_reg(CFG_PROP_GAIN, 16'd0);
    write_drive_reg(CFG_FF_GAIN,   16'd0);
    write_drive_reg(CFG_PPR,       16'd1);
    queue_random_steps(40);
    wait_drained();

    write_drive_reg(CFG_PROP_GAIN, 16'd300);
    write_drive_reg(CFG_FF_GAIN,   16'hFFEC);
    write_drive_reg(CFG_PPR,       16'd4096);
    queue_random_steps(120);
    wait_drained();

    $display("Checked %0d drive results over %0d register writes and seven settings.",
             results_seen, cfg_writes);
    $display("%0d steps reused the held speed, %0d braked and %0d clipped the duty.",
             held_steps, braked, clipped);
    if (mismatches == 0 && drive_owed_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches, %0d results never arrived",
               mismatches, drive_owed_q.size());
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
